@@ design/plct_pkg.sv @@
// ----------------------------------------------------------------------------
// plct_pkg
// Shared types and constants of the piecewise linear curve table unit.
// ----------------------------------------------------------------------------
package plct_pkg;

  localparam int unsigned MaxKeys = 32;
  localparam int unsigned IdxW    = $clog2(MaxKeys);
  localparam int unsigned CntW    = $clog2(MaxKeys + 1);
  localparam int unsigned DataW   = 24;
  localparam int unsigned ProdW   = 2 * (DataW + 1);
  localparam int unsigned QuoW    = DataW + 2;

  localparam logic [2:0] MODE_EVAL   = 3'd0;
  localparam logic [2:0] MODE_ADD    = 3'd1;
  localparam logic [2:0] MODE_REMOVE = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_ALTER  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_INDEX = 2'd3;

  localparam logic [1:0] CFG_TIME_LO  = 2'd0;
  localparam logic [1:0] CFG_TIME_HI  = 2'd1;
  localparam logic [1:0] CFG_VALUE_LO = 2'd2;
  localparam logic [1:0] CFG_VALUE_HI = 2'd3;

  typedef struct packed {
    logic [2:0]              mode;
    logic signed [DataW-1:0] point_time;
    logic signed [DataW-1:0] point_value;
    logic [4:0]              key_index;
  } plct_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] curve_value;
    logic [5:0]              keys_held;
    logic [1:0]              status;
  } plct_out_t;

  typedef struct packed {
    logic signed [DataW-1:0] t;
    logic signed [DataW-1:0] v;
  } plct_key_t;

endpackage

@@ design/plct_div.sv @@
// ----------------------------------------------------------------------------
// plct_div
// Serial restoring divider, one quotient bit per cycle, signed numerator,
// positive denominator, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module plct_div
  import plct_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ProdW-1:0] num_i,
  input  logic [DataW:0]          den_i,
  output logic                    done_o,
  output logic signed [QuoW-1:0]  quo_o
);

  localparam int unsigned StepW = $clog2(ProdW + 1);

  logic [ProdW-1:0] mag_q;
  logic [DataW:0]   rem_q;
  logic [DataW:0]   den_q;
  logic             neg_q;
  logic             run_q;
  logic             done_q;
  logic [StepW-1:0] cnt_q;

  logic [DataW+1:0] rem_sh;
  logic [DataW+1:0] rem_sub;
  logic             fits;
  logic [QuoW-1:0]  quo_mag;

  assign rem_sh  = {rem_q, mag_q[ProdW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = rem_sh >= {1'b0, den_q};
  assign quo_mag = mag_q[QuoW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= StepW'(ProdW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == StepW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= num_i[ProdW-1] ? ProdW'(-num_i) : ProdW'(num_i);
      neg_q <= num_i[ProdW-1];
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      mag_q <= {mag_q[ProdW-2:0], fits};
      rem_q <= fits ? rem_sub[DataW:0] : rem_sh[DataW:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed(quo_mag) : $signed(quo_mag);

endmodule

@@ design/piecewise_linear_curve_table_unit.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_curve_table_unit
// Sorted breakpoint table with linear interpolation between keys.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; its one result
// word appears on result_o for exactly one cycle with done_o high and must be
// captured then. The keys live in a table with one read port and one write
// port, read one entry per cycle, and interpolation uses a bit-serial divider.
// Evaluate reports empty when the table is empty, reads the first or last
// key when clamped, and otherwise scans the keys, multiplying and dividing
// when it interpolates. Add and remove move one key at a time; alter of an
// inner key is a remove then an add; clear and an alter of the first or last
// key move no keys.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_table_unit
  import plct_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  plct_in_t                item_i,
  output logic                    done_o,
  output plct_out_t               result_o,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [DataW-1:0]        cfg_wdata_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL_PICK, S_EVAL_SCAN, S_MUL, S_DIV_GO, S_DIV,
    S_INS_RD, S_INS_CK, S_DEL_RD, S_DEL_WR, S_ALT_WR
  } state_e;

  state_e                  state_q;
  logic signed [DataW-1:0] tlo_q, thi_q, vlo_q, vhi_q;
  logic [CntW-1:0]         total_q, j_q;
  logic signed [DataW-1:0] t_q, v_q, va_q;
  logic [IdxW-1:0]         idx_q;
  logic                    alter_q, done_q;
  plct_key_t               prev_q, rdata_q;
  plct_out_t               out_q;
  logic signed [DataW:0]   dt_q, dv_q;
  logic [DataW:0]          den_q;
  logic signed [ProdW-1:0] prod_q;

  plct_key_t               mem_q [MaxKeys];
  logic                    we;
  logic [IdxW-1:0]         waddr, raddr;
  plct_key_t               wdata;

  logic                    div_done;
  logic signed [QuoW-1:0]  quo;
  logic signed [QuoW:0]    interp;

  logic                    accept;
  logic [CntW-1:0]         last, j_inc, j_dec, in_idx;
  logic signed [DataW-1:0] in_vc, in_tc;

  assign accept = start && !busy;
  assign last   = total_q - 1'b1;
  assign j_inc  = j_q + 1'b1;
  assign j_dec  = j_q - 1'b1;
  assign in_idx = CntW'(item_i.key_index);
  assign interp = (QuoW+1)'(va_q) + (QuoW+1)'(quo);

  always_comb begin
    in_vc = (item_i.point_value < vlo_q) ? vlo_q : item_i.point_value;
    in_vc = (in_vc > vhi_q) ? vhi_q : in_vc;
    in_tc = (item_i.point_time < tlo_q) ? tlo_q : item_i.point_time;
    in_tc = (in_tc > thi_q) ? thi_q : in_tc;
  end

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = j_q[IdxW-1:0];
    wdata = '{t: t_q, v: v_q};
    unique case (state_q)
      S_IDLE: begin
        if (item_i.mode == MODE_ALTER) begin
          raddr = item_i.key_index[IdxW-1:0];
        end else if (item_i.point_time > tlo_q && item_i.point_time >= thi_q) begin
          raddr = last[IdxW-1:0];
        end
      end
      S_EVAL_SCAN: raddr = j_inc[IdxW-1:0];
      S_INS_RD: begin
        raddr = j_dec[IdxW-1:0];
        we    = (j_q == '0);
      end
      S_INS_CK: begin
        we = 1'b1;
        if (rdata_q.t > t_q) wdata = rdata_q;
      end
      S_DEL_RD: raddr = j_inc[IdxW-1:0];
      S_DEL_WR: begin
        we    = 1'b1;
        wdata = rdata_q;
      end
      S_ALT_WR: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = '{t: rdata_q.t, v: v_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  plct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DIV_GO),
    .num_i   (prod_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tlo_q   <= DataW'(0);
      thi_q   <= DataW'(25600);
      vlo_q   <= DataW'(0);
      vhi_q   <= DataW'(25600);
      total_q <= '0;
      j_q     <= '0;
      alter_q <= 1'b0;
      done_q  <= 1'b0;
      out_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TIME_LO:  tlo_q <= cfg_wdata_i;
          CFG_TIME_HI:  thi_q <= cfg_wdata_i;
          CFG_VALUE_LO: vlo_q <= cfg_wdata_i;
          CFG_VALUE_HI: vhi_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            t_q     <= item_i.point_time;
            v_q     <= item_i.point_value;
            idx_q   <= item_i.key_index[IdxW-1:0];
            alter_q <= 1'b0;
            out_q   <= '{curve_value: '0, keys_held: total_q, status: ST_OK};
            case (item_i.mode)
              MODE_EVAL: begin
                if (total_q == '0) begin
                  out_q.status <= ST_EMPTY;
                  done_q       <= 1'b1;
                end else if (item_i.point_time <= tlo_q || item_i.point_time >= thi_q) begin
                  state_q <= S_EVAL_PICK;
                end else begin
                  j_q     <= '0;
                  state_q <= S_EVAL_SCAN;
                end
              end
              MODE_ADD: begin
                if (total_q == CntW'(MaxKeys)) begin
                  out_q.status <= ST_FULL;
                  done_q       <= 1'b1;
                end else begin
                  j_q     <= total_q;
                  state_q <= S_INS_RD;
                end
              end
              MODE_REMOVE: begin
                if (in_idx >= total_q) begin
                  out_q.status <= ST_INDEX;
                  done_q       <= 1'b1;
                end else begin
                  j_q     <= in_idx;
                  state_q <= S_DEL_RD;
                end
              end
              MODE_CLEAR: begin
                total_q         <= '0;
                out_q.keys_held <= '0;
                done_q          <= 1'b1;
              end
              MODE_ALTER: begin
                v_q <= in_vc;
                t_q <= in_tc;
                if (in_idx >= total_q) begin
                  out_q.status <= ST_INDEX;
                  done_q       <= 1'b1;
                end else if (in_idx == '0 || in_idx == last) begin
                  state_q <= S_ALT_WR;
                end else begin
                  j_q     <= in_idx;
                  alter_q <= 1'b1;
                  state_q <= S_DEL_RD;
                end
              end
              default: done_q <= 1'b1;
            endcase
          end
        end
        S_EVAL_PICK: begin
          out_q.curve_value <= rdata_q.v;
          done_q            <= 1'b1;
          state_q           <= S_IDLE;
        end
        S_EVAL_SCAN: begin
          if (j_q != '0 && prev_q.t == t_q) begin
            out_q.curve_value <= prev_q.v;
            done_q            <= 1'b1;
            state_q           <= S_IDLE;
          end else if (j_q != '0 && prev_q.t <= t_q && rdata_q.t > t_q) begin
            va_q    <= prev_q.v;
            dt_q    <= (DataW+1)'(t_q) - (DataW+1)'(prev_q.t);
            dv_q    <= (DataW+1)'(rdata_q.v) - (DataW+1)'(prev_q.v);
            den_q   <= (DataW+1)'(rdata_q.t) - (DataW+1)'(prev_q.t);
            state_q <= S_MUL;
          end else if (j_q == last) begin
            out_q.curve_value <= rdata_q.v;
            done_q            <= 1'b1;
            state_q           <= S_IDLE;
          end else begin
            prev_q <= rdata_q;
            j_q    <= j_inc;
          end
        end
        S_MUL: begin
          prod_q  <= dt_q * dv_q;
          state_q <= S_DIV_GO;
        end
        S_DIV_GO: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            out_q.curve_value <= interp[DataW-1:0];
            done_q            <= 1'b1;
            state_q           <= S_IDLE;
          end
        end
        S_INS_RD: begin
          if (j_q == '0) begin
            total_q         <= total_q + 1'b1;
            out_q.keys_held <= total_q + 1'b1;
            done_q          <= 1'b1;
            state_q         <= S_IDLE;
          end else begin
            state_q <= S_INS_CK;
          end
        end
        S_INS_CK: begin
          if (rdata_q.t > t_q) begin
            j_q     <= j_dec;
            state_q <= S_INS_RD;
          end else begin
            total_q         <= total_q + 1'b1;
            out_q.keys_held <= total_q + 1'b1;
            done_q          <= 1'b1;
            state_q         <= S_IDLE;
          end
        end
        S_DEL_RD: begin
          if (j_inc >= total_q) begin
            total_q <= last;
            if (alter_q) begin
              j_q     <= last;
              state_q <= S_INS_RD;
            end else begin
              out_q.keys_held <= last;
              done_q          <= 1'b1;
              state_q         <= S_IDLE;
            end
          end else begin
            state_q <= S_DEL_WR;
          end
        end
        S_DEL_WR: begin
          j_q     <= j_inc;
          state_q <= S_DEL_RD;
        end
        S_ALT_WR: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = out_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
  a_total_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CntW'(MaxKeys)) else $error("key count overflow");
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status == ST_FULL |-> result_o.keys_held == CntW'(MaxKeys))
    else $error("full status with free slots");
  a_keys_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.keys_held == total_q) else $error("key count mismatch");

endmodule

@@ tb/sv/piecewise_linear_curve_table_unit_test.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_curve_table_unit_test
// Drives command words into the curve table unit: directed cases, then random
// sequences under several bound settings. Each word is predicted by a local
// model of the sorted key table, and each result word is checked against the
// oldest prediction.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_table_unit_test;
  import plct_pkg::*;

  localparam int CycleLimit = 2000000;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  plct_in_t         item_i;
  logic             done_o;
  plct_out_t        result_o;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [DataW-1:0] cfg_wdata_i;

  piecewise_linear_curve_table_unit dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .done_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  int        time_lo, time_hi, value_lo, value_hi;
  int        key_t [MaxKeys];
  int        key_v [MaxKeys];
  int        key_count;
  plct_out_t expected_words[$];
  int        errors;
  int        cycles;
  int        burst_left;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("piecewise_linear_curve_table_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    plct_out_t exp_w;
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word actual %h", $time, result_o);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (result_o.curve_value !== exp_w.curve_value)
          begin $display("%0t curve_value expected %0d actual %0d", $time,
            exp_w.curve_value, result_o.curve_value); errors++; end
        if (result_o.keys_held !== exp_w.keys_held)
          begin $display("%0t keys_held expected %0d actual %0d", $time,
            exp_w.keys_held, result_o.keys_held); errors++; end
        if (result_o.status !== exp_w.status)
          begin $display("%0t status expected %0d actual %0d", $time,
            exp_w.status, result_o.status); errors++; end
      end
    end
  end

  function automatic int clamp_int(int x, int lo, int hi);
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    return x;
  endfunction

  function automatic void insert_key(int t, int v);
    int pos;
    pos = 0;
    while (pos < key_count && key_t[pos] <= t) pos++;
    for (int j = key_count; j > pos; j--) begin
      key_t[j] = key_t[j-1];
      key_v[j] = key_v[j-1];
    end
    key_t[pos] = t;
    key_v[pos] = v;
    key_count++;
  endfunction

  function automatic void drop_key(int idx);
    for (int j = idx; j + 1 < key_count; j++) begin
      key_t[j] = key_t[j+1];
      key_v[j] = key_v[j+1];
    end
    key_count--;
  endfunction

  function automatic int curve_at(int t);
    longint num, den;
    int last;
    last = key_count - 1;
    if (t <= time_lo) return key_v[0];
    if (t >= time_hi) return key_v[last];
    for (int i = 0; i < last; i++) begin
      if (key_t[i] == t) return key_v[i];
      if (key_t[i] <= t && key_t[i+1] > t) begin
        num = (longint'(t) - key_t[i]) * (longint'(key_v[i+1]) - key_v[i]);
        den = longint'(key_t[i+1]) - key_t[i];
        return int'(longint'(key_v[i]) + num / den);
      end
    end
    return key_v[last];
  endfunction

  function automatic plct_out_t apply_command(plct_in_t w);
    plct_out_t r;
    int t, v, idx;
    t = int'(w.point_time);
    v = int'(w.point_value);
    idx = int'(w.key_index);
    r = '0;
    case (w.mode)
      MODE_EVAL: begin
        if (key_count == 0) r.status = ST_EMPTY;
        else r.curve_value = DataW'(curve_at(t));
      end
      MODE_ADD: begin
        if (key_count >= MaxKeys) r.status = ST_FULL;
        else insert_key(t, v);
      end
      MODE_REMOVE: begin
        if (idx >= key_count) r.status = ST_INDEX;
        else drop_key(idx);
      end
      MODE_CLEAR: key_count = 0;
      MODE_ALTER: begin
        if (idx >= key_count) r.status = ST_INDEX;
        else if (idx == 0 || idx == key_count - 1)
          key_v[idx] = clamp_int(v, value_lo, value_hi);
        else begin
          drop_key(idx);
          insert_key(clamp_int(t, time_lo, time_hi), clamp_int(v, value_lo, value_hi));
        end
      end
      default: ;
    endcase
    r.keys_held = 6'(key_count);
    return r;
  endfunction

  task automatic send_command(logic [2:0] mode, int t, int v, int idx);
    plct_in_t w;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
    end
    burst_left--;
    w.mode = mode;
    w.point_time = t[23:0];
    w.point_value = v[23:0];
    w.key_index = idx[4:0];
    start <= 1'b1;
    item_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_words.push_back(apply_command(w));
    @(negedge clk_i);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic write_bound(logic [1:0] idx, int val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[23:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TIME_LO:  time_lo = val;
      CFG_TIME_HI:  time_hi = val;
      CFG_VALUE_LO: value_lo = val;
      default:      value_hi = val;
    endcase
  endtask

  task automatic set_bounds(int tl, int th, int vl, int vh);
    write_bound(CFG_TIME_LO, tl);
    write_bound(CFG_TIME_HI, th);
    write_bound(CFG_VALUE_LO, vl);
    write_bound(CFG_VALUE_HI, vh);
  endtask

  function automatic int rand_q(int span);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return $signed($urandom() << 8) >>> 8;
    if (r == 1) return (r == 1 && $urandom_range(0, 1)) ? 32'sh7fffff : -32'sh800000;
    return $urandom_range(0, 2 * span) - span;
  endfunction

  task automatic test_directed;
    send_command(MODE_EVAL, 0, 0, 0);
    send_command(MODE_REMOVE, 0, 0, 0);
    send_command(MODE_ALTER, 0, 0, 31);
    send_command(MODE_ADD, 2560, 1000, 0);
    send_command(MODE_ADD, 12800, -3000, 0);
    send_command(MODE_ADD, 12800, 7000, 0);
    send_command(MODE_ADD, 25600, 8388607, 0);
    send_command(MODE_EVAL, -8388608, 0, 0);
    send_command(MODE_EVAL, 8388607, 0, 0);
    send_command(MODE_EVAL, 12800, 0, 0);
    send_command(MODE_EVAL, 5000, 0, 0);
    send_command(MODE_EVAL, 20001, 0, 0);
    send_command(MODE_ALTER, 99999, -8388608, 0);
    send_command(MODE_ALTER, 99999, 8388607, 3);
    send_command(MODE_ALTER, -8388608, 500, 1);
    send_command(MODE_ALTER, 8388607, 500, 1);
    send_command(MODE_EVAL, 100, 0, 0);
    send_command(MODE_REMOVE, 0, 0, 4);
    send_command(MODE_REMOVE, 0, 0, 1);
    send_command(3'd5, 0, 0, 0);
    send_command(3'd7, -1, -1, 31);
    for (int i = 0; i < 33; i++) send_command(MODE_ADD, i * 700, i * 50, 0);
    send_command(MODE_CLEAR, 0, 0, 0);
    send_command(MODE_EVAL, 0, 0, 0);
  endtask

  task automatic test_random(int count, int span);
    int m;
    for (int n = 0; n < count; n++) begin
      m = $urandom_range(0, 99);
      if (m < 35) send_command(MODE_EVAL, rand_q(span), rand_q(span), $urandom());
      else if (m < 65) send_command(MODE_ADD, rand_q(span), rand_q(span), $urandom());
      else if (m < 78) send_command(MODE_REMOVE, rand_q(span), rand_q(span),
        $urandom_range(0, key_count < 31 ? key_count + 1 : 31));
      else if (m < 95) send_command(MODE_ALTER, rand_q(span), rand_q(span),
        $urandom_range(0, 31));
      else if (m < 97) send_command(MODE_CLEAR, rand_q(span), rand_q(span), $urandom());
      else send_command(3'($urandom_range(5, 7)), rand_q(span), rand_q(span), $urandom());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TIME_LO;
    cfg_wdata_i = '0;
    errors = 0;
    cycles = 0;
    burst_left = 0;
    time_lo = 0;
    time_hi = 25600;
    value_lo = 0;
    value_hi = 25600;
    key_count = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(600, 30000);
    set_bounds(-8388608, 8388607, -8388608, 8388607);
    test_random(500, 8388607);
    set_bounds(-5000, 5000, -2000, 2000);
    test_random(500, 8000);
    set_bounds(3000, -3000, 100, -100);
    test_random(400, 6000);
    drain();
    if (errors == 0) $display("piecewise_linear_curve_table_unit verification clean");
    else $display("piecewise_linear_curve_table_unit verification failed");
    $finish;
  end

endmodule
